[rtl/huffman_rle_symbol_encoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run-length Huffman symbol encoder
// Shared wrappers that keep clocking and reset handling uniform.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_RLE_SYMBOL_ENCODER_CORE_MACROS_SVH
`define HUFFMAN_RLE_SYMBOL_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HRSE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrse assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define HRSE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrse assertion failed: next-cycle implication");

`endif

[rtl/hrse_pkg.sv]
// ----------------------------------------------------------------------------
// hrse_pkg
// Constants, command and state codes, and shared types of the encoder.
// ----------------------------------------------------------------------------
package hrse_pkg;

   localparam int SYMBOL_BITS    = 16;
   localparam int MAX_CODE_LEN   = 58;
   localparam int WORD_BITS      = 64;
   localparam int LEN_BITS       = 6;
   localparam int CODE_BITS      = WORD_BITS - LEN_BITS;
   localparam int INDEX_BITS     = SYMBOL_BITS + 1;
   localparam int TABLE_DEPTH    = (2 ** SYMBOL_BITS) + 1;
   localparam int RUN_BITS       = 8;
   localparam int REP_BITS       = 6;
   localparam int LANES          = 8;

   localparam logic [INDEX_BITS-1:0] TABLE_LAST     = INDEX_BITS'(2 ** SYMBOL_BITS);
   localparam logic [RUN_BITS-1:0]   RUN_ESCAPE_MIN = 8'd32;
   localparam logic [RUN_BITS-1:0]   RUN_MAX        = 8'd255;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_SYM,
      ST_LD_SYM,
      ST_PUSH_SYM,
      ST_RD_RUN,
      ST_LD_RUN,
      ST_PUSH_RUN,
      ST_PUSH_CNT,
      ST_END,
      ST_PAD,
      ST_FINAL
   } state_type;

   // Code bits left aligned, MSB first, with the number of valid bits.
   typedef struct packed {
      logic [CODE_BITS-1:0] bits;
      logic [LEN_BITS-1:0]  len;
   } code_src_type;

   typedef struct packed {
      code_src_type src;
      logic [6:0]   res;
      logic [2:0]   res_cnt;
   } push_in_type;

   typedef struct packed {
      code_src_type src;
      logic [6:0]   res;
      logic [2:0]   res_cnt;
      logic [3:0]   take;
      logic         byte_valid;
      logic [7:0]   byte_data;
   } push_out_type;

   // Clamps the length and moves the low len code bits to the top.
   function automatic code_src_type align_code(logic [WORD_BITS-1:0] word);
      code_src_type r;
      logic [LEN_BITS-1:0] len;
      len = word[LEN_BITS-1:0];
      if (len > LEN_BITS'(MAX_CODE_LEN)) begin
         len = LEN_BITS'(MAX_CODE_LEN);
      end
      r.len  = len;
      r.bits = word[WORD_BITS-1:LEN_BITS] << (LEN_BITS'(CODE_BITS) - len);
      return r;
   endfunction

endpackage

[rtl/hrse_push_unit.sv]
// ----------------------------------------------------------------------------
// hrse_push_unit
// Shared bit packer: moves up to one byte's worth of code bits per cycle
// from the code source into the residual byte.
// ----------------------------------------------------------------------------
module hrse_push_unit (
   input  hrse_pkg::push_in_type  pin,
   output hrse_pkg::push_out_type pout
);
   import hrse_pkg::*;

   logic [3:0] room;
   logic [3:0] take;
   logic [7:0] top_bits;
   logic [7:0] acc;
   logic [3:0] sum;

   always_comb begin
      room     = 4'd8 - {1'b0, pin.res_cnt};
      take     = ({2'b0, room} > pin.src.len) ? pin.src.len[3:0] : room;
      top_bits = pin.src.bits[CODE_BITS-1 -: 8] >> (4'd8 - take);
      acc      = ({1'b0, pin.res} << take) | top_bits;
      sum      = {1'b0, pin.res_cnt} + take;

      pout.take       = take;
      pout.byte_valid = (sum == 4'd8);
      pout.byte_data  = acc;
      pout.res        = pout.byte_valid ? 7'd0 : acc[6:0];
      pout.res_cnt    = sum[2:0];
      pout.src.bits   = pin.src.bits << take;
      pout.src.len    = pin.src.len - {2'b0, take};
   end

endmodule

[rtl/huffman_rle_symbol_encoder_core.sv]
// ----------------------------------------------------------------------------
// huffman_rle_symbol_encoder_core: run-length assisted Huffman encoder
// Flow: a load, a counted repeat or an ignored command passes through IDLE and
// DISPATCH. A symbol change then reads, loads and pushes each code (RD_SYM,
// LD_SYM, PUSH_SYM) and ends in END; an escape adds RD_RUN, LD_RUN, PUSH_RUN and
// PUSH_CNT for the run code and the count; a flush adds PAD and FINAL.
// The packer moves at most one byte per cycle; output stalls add cycles.
// Reset is synchronous and active high; the table memory is not cleared.
// ----------------------------------------------------------------------------
module huffman_rle_symbol_encoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [hrse_pkg::INDEX_BITS-1:0]  req_table_index,
   input  logic [hrse_pkg::WORD_BITS-1:0]   req_table_word,
   input  logic [15:0]                      req_symbol,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [63:0]                      rsp_out_bytes,
   output logic [3:0]                       rsp_byte_count,
   output logic [31:0]                      rsp_total_bits,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hrse_pkg::INDEX_BITS-1:0]  csr_run_code_index
);
   import hrse_pkg::*;

   logic [WORD_BITS-1:0] code_table_mem [0:TABLE_DEPTH-1];

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic [SYMBOL_BITS-1:0] sym_ff, sym_in;
   logic [SYMBOL_BITS-1:0] prev_ff, prev_in;
   logic                   have_ff, have_in;
   logic [RUN_BITS-1:0]    run_ff, run_in;
   logic [REP_BITS-1:0]    rep_ff, rep_in;
   logic                   esc_ff, esc_in;
   logic [6:0]             res_ff, res_in;
   logic [2:0]             res_cnt_ff, res_cnt_in;
   logic [31:0]            bit_total_ff, bit_total_in;
   code_src_type           src_ff, src_in;
   code_src_type           sym_src_ff, sym_src_in;
   logic [63:0]            chunk_ff, chunk_in;
   logic [3:0]             chunk_cnt_ff, chunk_cnt_in;
   logic [INDEX_BITS-1:0]  run_idx_ff, run_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            out_bytes_ff, out_bytes_in;
   logic [3:0]             byte_count_ff, byte_count_in;
   logic [31:0]            total_ff, total_in;
   logic                   last_ff, last_in;

   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_oor_ff;
   logic [INDEX_BITS-1:0]  rd_addr;
   logic                   tbl_we;

   push_in_type  pu_in;
   push_out_type pu_out;

   logic       out_free;
   logic       push_st;
   logic [7:0] pad_byte;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       chunk_full;
   logic       hold;
   logic       push_done;
   logic       same_run;
   logic       flush_cmd;
   code_src_type rd_src;

   hrse_push_unit u_push (
      .pin  (pu_in),
      .pout (pu_out)
   );

   assign pu_in.src     = src_ff;
   assign pu_in.res     = res_ff;
   assign pu_in.res_cnt = res_cnt_ff;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = !reset;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = out_bytes_ff;
   assign rsp_byte_count = byte_count_ff;
   assign rsp_total_bits = total_ff;
   assign rsp_last       = last_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign push_st    = (state_ff == ST_PUSH_SYM) || (state_ff == ST_PUSH_RUN) ||
                       (state_ff == ST_PUSH_CNT);
   assign pad_byte   = {1'b0, res_ff} << (4'd8 - {1'b0, res_cnt_ff});
   assign byte_valid = push_st ? pu_out.byte_valid
                               : ((state_ff == ST_PAD) && (res_cnt_ff != 3'd0));
   assign byte_data  = push_st ? pu_out.byte_data : pad_byte;
   assign chunk_full = (chunk_cnt_ff == 4'd8);
   // A finished byte with a full chunk must first hand the chunk to the output.
   assign hold       = byte_valid && chunk_full && !out_free;
   assign push_done  = (pu_out.src.len == '0);
   assign same_run   = (sym_ff == prev_ff) && (run_ff < RUN_MAX);
   assign flush_cmd  = (cmd_ff == CMD_FLUSH);
   assign rd_src     = align_code(rd_data_ff);

   assign rd_addr = (state_ff == ST_RD_RUN) ? run_idx_ff : {1'b0, prev_ff};

   // Code table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         code_table_mem[idx_ff] <= word_ff;
      end
      rd_data_ff <= code_table_mem[rd_addr];
      rd_oor_ff  <= (rd_addr > TABLE_LAST);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_ENCODE: state_in = (have_ff && !same_run) ? ST_RD_SYM : ST_IDLE;
               CMD_FLUSH:  state_in = have_ff ? ST_RD_SYM : ST_PAD;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_RD_SYM: state_in = ST_LD_SYM;
         ST_LD_SYM: state_in = ST_PUSH_SYM;
         ST_PUSH_SYM: begin
            if (!hold && push_done) begin
               if (esc_ff) begin
                  state_in = ST_RD_RUN;
               end else if (rep_ff == '0) begin
                  state_in = ST_END;
               end
            end
         end
         ST_RD_RUN: state_in = ST_LD_RUN;
         ST_LD_RUN: state_in = ST_PUSH_RUN;
         ST_PUSH_RUN: begin
            if (!hold && push_done) begin
               state_in = ST_PUSH_CNT;
            end
         end
         ST_PUSH_CNT: begin
            if (!hold && push_done) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (flush_cmd) begin
               state_in = ST_PAD;
            end else if ((chunk_cnt_ff == 4'd0) || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (!hold) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      sym_in        = sym_ff;
      prev_in       = prev_ff;
      have_in       = have_ff;
      run_in        = run_ff;
      rep_in        = rep_ff;
      esc_in        = esc_ff;
      res_in        = res_ff;
      res_cnt_in    = res_cnt_ff;
      bit_total_in  = bit_total_ff;
      src_in        = src_ff;
      sym_src_in    = sym_src_ff;
      chunk_in      = chunk_ff;
      chunk_cnt_in  = chunk_cnt_ff;
      run_idx_in    = run_idx_ff;
      tbl_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      out_bytes_in  = out_bytes_ff;
      byte_count_in = byte_count_ff;
      total_in      = total_ff;
      last_in       = last_ff;

      if (csr_valid && csr_ready) begin
         run_idx_in = csr_run_code_index;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = cmd_type'(req_cmd);
               idx_in  = req_table_index;
               word_in = req_table_word;
               sym_in  = req_symbol[SYMBOL_BITS-1:0];
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_LOAD: tbl_we = (idx_ff <= TABLE_LAST);
               CMD_ENCODE: begin
                  if (!have_ff) begin
                     have_in = 1'b1;
                     prev_in = sym_ff;
                     run_in  = '0;
                  end else if (same_run) begin
                     run_in = run_ff + 8'd1;
                  end
               end
               default: ;
            endcase
         end
         ST_LD_SYM: begin
            src_in     = rd_src;
            sym_src_in = rd_src;
            esc_in     = (run_ff > RUN_ESCAPE_MIN);
            rep_in     = run_ff[REP_BITS-1:0];
         end
         ST_LD_RUN: begin
            src_in = rd_src;
            if (rd_oor_ff) begin
               src_in.len = '0;
            end
         end
         default: ;
      endcase

      // One packer step; the escape count follows the run code.
      if (push_st && !hold) begin
         src_in       = pu_out.src;
         res_in       = pu_out.res;
         res_cnt_in   = pu_out.res_cnt;
         bit_total_in = bit_total_ff + {28'd0, pu_out.take};
         if (push_done) begin
            if ((state_ff == ST_PUSH_SYM) && !esc_ff && (rep_ff != '0)) begin
               rep_in = rep_ff - 6'd1;
               src_in = sym_src_ff;
            end else if (state_ff == ST_PUSH_RUN) begin
               src_in.bits = {run_ff, (CODE_BITS - RUN_BITS)'(0)};
               src_in.len  = LEN_BITS'(RUN_BITS);
            end
         end
      end

      if (state_ff == ST_PAD && !hold) begin
         res_in     = '0;
         res_cnt_in = '0;
      end

      // Collect finished bytes into the chunk, handing a full chunk over first.
      if (byte_valid && !hold) begin
         if (chunk_full) begin
            rsp_valid_in  = 1'b1;
            out_bytes_in  = chunk_ff;
            byte_count_in = 4'd8;
            total_in      = '0;
            last_in       = 1'b0;
            chunk_in      = {byte_data, 56'd0};
            chunk_cnt_in  = 4'd1;
         end else begin
            for (int i = 0; i < LANES; i++) begin
               if (chunk_cnt_ff[2:0] == 3'(i)) begin
                  chunk_in[63 - 8*i -: 8] = byte_data;
               end
            end
            chunk_cnt_in = chunk_cnt_ff + 4'd1;
         end
      end

      if (state_ff == ST_END && !flush_cmd) begin
         if ((chunk_cnt_ff != 4'd0) && out_free) begin
            rsp_valid_in  = 1'b1;
            out_bytes_in  = chunk_ff;
            byte_count_in = chunk_cnt_ff;
            total_in      = '0;
            last_in       = 1'b0;
            chunk_in      = '0;
            chunk_cnt_in  = '0;
         end
         if ((chunk_cnt_ff == 4'd0) || out_free) begin
            prev_in = sym_ff;
            run_in  = '0;
         end
      end

      if (state_ff == ST_FINAL && out_free) begin
         rsp_valid_in  = 1'b1;
         out_bytes_in  = chunk_ff;
         byte_count_in = chunk_cnt_ff;
         total_in      = bit_total_ff;
         last_in       = 1'b1;
         chunk_in      = '0;
         chunk_cnt_in  = '0;
         have_in       = 1'b0;
         prev_in       = '0;
         run_in        = '0;
         res_in        = '0;
         res_cnt_in    = '0;
         bit_total_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         run_ff       <= '0;
         res_ff       <= '0;
         res_cnt_ff   <= '0;
         bit_total_ff <= '0;
         chunk_ff     <= '0;
         chunk_cnt_ff <= '0;
         run_idx_ff   <= TABLE_LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         run_ff       <= run_in;
         res_ff       <= res_in;
         res_cnt_ff   <= res_cnt_in;
         bit_total_ff <= bit_total_in;
         chunk_ff     <= chunk_in;
         chunk_cnt_ff <= chunk_cnt_in;
         run_idx_ff   <= run_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      word_ff       <= word_in;
      sym_ff        <= sym_in;
      rep_ff        <= rep_in;
      esc_ff        <= esc_in;
      src_ff        <= src_in;
      sym_src_ff    <= sym_src_in;
      out_bytes_ff  <= out_bytes_in;
      byte_count_ff <= byte_count_in;
      total_ff      <= total_in;
      last_ff       <= last_in;
   end

endmodule

[rtl/hrse_checker.sv]
// ----------------------------------------------------------------------------
// hrse_checker
// Port-level checks on the result channel of the encoder, bound to the top.
// ----------------------------------------------------------------------------
`include "huffman_rle_symbol_encoder_core_macros.svh"

module hrse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_byte_count,
   input logic [31:0] rsp_total_bits,
   input logic        rsp_last
);

   // Only the closing result of a block reports the bit total.
   `HRSE_ASSERT_IMP(a_total_only_last, clock, reset, rsp_valid && !rsp_last, rsp_total_bits == 32'd0)

   // Results before the closing one always carry at least one byte.
   `HRSE_ASSERT_IMP(a_nonlast_has_bytes, clock, reset, rsp_valid && !rsp_last, rsp_byte_count != 4'd0)

   `HRSE_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_byte_count <= 4'd8)

   // A stalled transfer keeps its bytes.
   `HRSE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_bytes))

endmodule

bind huffman_rle_symbol_encoder_core hrse_checker u_hrse_checker (.*);

[tb/sv/tb_huffman_rle_symbol_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for huffman_rle_symbol_encoder_core
// Loads code tables and streams symbols, runs and end-of-block flushes through
// the encoder. It predicts every packed output transfer in the testbench
// itself and compares the outputs field by field, with random idling on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_huffman_rle_symbol_encoder_core;
   import hrse_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 25;
   localparam int MAX_CHUNKS    = 32;
   localparam int MAX_REPORTS   = 30;
   localparam int LEN_FIELD_MAX = (1 << LEN_BITS) - 1;
   localparam logic [INDEX_BITS-1:0] INDEX_ALL_ONES = '1;

   typedef struct {
      logic [63:0] bytes_word;
      logic [3:0]  n_bytes;
      logic [31:0] bit_total;
      logic        last;
   } coded_chunk_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_cmd;
   logic [INDEX_BITS-1:0] req_table_index;
   logic [WORD_BITS-1:0]  req_table_word;
   logic [15:0]           req_symbol;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [63:0]           rsp_out_bytes;
   logic [3:0]            rsp_byte_count;
   logic [31:0]           rsp_total_bits;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [INDEX_BITS-1:0] csr_run_code_index;

   // Encoder state as the testbench sees it.
   logic [63:0]           code_words [0:TABLE_DEPTH-1];
   logic [INDEX_BITS-1:0] escape_index = TABLE_LAST;
   logic [15:0]           cur_symbol = '0;
   bit                    symbol_open = 1'b0;
   int                    repeat_count = 0;
   logic [7:0]            frag_bits = '0;
   int                    frag_count = 0;
   logic [31:0]           block_bits = '0;
   logic [7:0]            byte_stream [$];
   coded_chunk_type       chunk_q [$];

   logic [15:0] known_symbols [$];
   bit          idle_on = 1'b0;
   int          rsp_hold_cycles = 0;
   int          cycle_count = 0;
   int          requests_sent = 0;
   int          chunks_checked = 0;
   int          escapes_predicted = 0;
   int          mismatches = 0;

   huffman_rle_symbol_encoder_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_table_index    (req_table_index),
      .req_table_word     (req_table_word),
      .req_symbol         (req_symbol),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_bytes      (rsp_out_bytes),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_total_bits     (rsp_total_bits),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_run_code_index (csr_run_code_index)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, chunk_q.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] table_entry(logic [INDEX_BITS-1:0] index);
      if (index > TABLE_LAST) begin
         return '0;
      end
      return code_words[index];
   endfunction

   function automatic void pack_bits(int len, logic [63:0] val);
      for (int i = len - 1; i >= 0; i--) begin
         frag_bits = {frag_bits[6:0], val[i]};
         frag_count++;
         if (frag_count == 8) begin
            byte_stream.push_back(frag_bits);
            frag_bits  = '0;
            frag_count = 0;
         end
      end
      block_bits = block_bits + 32'(len);
   endfunction

   function automatic void pack_code(logic [63:0] word);
      int          len;
      logic [63:0] val;
      len = int'(word[LEN_BITS-1:0]);
      if (len > MAX_CODE_LEN) begin
         len = MAX_CODE_LEN;
      end
      if (len == 0) begin
         return;
      end
      val = (word >> LEN_BITS) & ((64'd1 << len) - 64'd1);
      pack_bits(len, val);
   endfunction

   function automatic void flush_pending_run();
      logic [63:0] sym_word;
      sym_word = table_entry({1'b0, cur_symbol});
      if (repeat_count > RUN_ESCAPE_MIN) begin
         pack_code(sym_word);
         pack_code(table_entry(escape_index));
         pack_bits(RUN_BITS, 64'(repeat_count));
         escapes_predicted++;
      end else begin
         for (int k = 0; k <= repeat_count; k++) begin
            pack_code(sym_word);
         end
      end
   endfunction

   // Splits the bytes of one request into transfers of up to eight bytes.
   function automatic void capture_chunks(bit end_of_block);
      coded_chunk_type c;
      int              pos;
      int              n;
      int              nres;
      pos  = 0;
      nres = 0;
      do begin
         c.bytes_word = '0;
         n = byte_stream.size() - pos;
         if (n > LANES) begin
            n = LANES;
         end
         for (int k = 0; k < n; k++) begin
            c.bytes_word |= 64'(byte_stream[pos + k]) << (8 * (LANES - 1 - k));
         end
         pos += n;
         c.n_bytes   = 4'(n);
         c.last      = end_of_block && (pos >= byte_stream.size());
         c.bit_total = c.last ? block_bits : '0;
         chunk_q.push_back(c);
         nres++;
      end while (pos < byte_stream.size() && nres < MAX_CHUNKS);
   endfunction

   function automatic void predict_chunks(cmd_type cmd, logic [INDEX_BITS-1:0] index,
                                          logic [63:0] word, logic [15:0] sym);
      byte_stream.delete();
      case (cmd)
         CMD_LOAD: begin
            if (index <= TABLE_LAST) begin
               code_words[index] = word;
            end
         end
         CMD_ENCODE: begin
            if (!symbol_open) begin
               symbol_open  = 1'b1;
               cur_symbol   = sym;
               repeat_count = 0;
            end else if (sym == cur_symbol && repeat_count < RUN_MAX) begin
               repeat_count++;
            end else begin
               flush_pending_run();
               repeat_count = 0;
               cur_symbol   = sym;
               if (byte_stream.size() != 0) begin
                  capture_chunks(1'b0);
               end
            end
         end
         CMD_FLUSH: begin
            if (symbol_open) begin
               flush_pending_run();
            end
            if (frag_count > 0) begin
               byte_stream.push_back(8'(frag_bits << (8 - frag_count)));
            end
            capture_chunks(1'b1);
            cur_symbol   = '0;
            symbol_open  = 1'b0;
            repeat_count = 0;
            frag_bits    = '0;
            frag_count   = 0;
            block_bits   = '0;
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("cycle %0d: %s mismatch, expected %h, got %h", cycle_count, what, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      coded_chunk_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (chunk_q.size() == 0) begin
            report_mismatch("unexpected transfer", '0, rsp_out_bytes);
         end else begin
            want = chunk_q.pop_front();
            chunks_checked++;
            if (rsp_out_bytes !== want.bytes_word) begin
               report_mismatch("out_bytes", want.bytes_word, rsp_out_bytes);
            end
            if (rsp_byte_count !== want.n_bytes) begin
               report_mismatch("byte_count", 64'(want.n_bytes), 64'(rsp_byte_count));
            end
            if (rsp_total_bits !== want.bit_total) begin
               report_mismatch("total_bits", 64'(want.bit_total), 64'(rsp_total_bits));
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", 64'(want.last), 64'(rsp_last));
            end
         end
      end
   end

   // ---------------------------------------------------------------- pacing

   function automatic int idle_gap();
      int r;
      if (!idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Output side: random stalls, or one long hold-off when a test asks for it.
   always begin : rsp_pacing
      int n;
      @(posedge clock);
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (rsp_hold_cycles) @(posedge clock);
         rsp_hold_cycles = 0;
         rsp_stall <= 1'b0;
      end else if (!reset && $urandom_range(0, 3) == 0) begin
         n = idle_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Valid stays high between back-to-back transfers; it only drops for a gap.
   task automatic send_request(cmd_type cmd, logic [INDEX_BITS-1:0] index,
                               logic [63:0] word, logic [15:0] sym);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_table_index <= index;
      req_table_word  <= word;
      req_symbol      <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_chunks(cmd, index, word, sym);
      requests_sent++;
   endtask

   task automatic load_entry(logic [INDEX_BITS-1:0] index, logic [63:0] word);
      send_request(CMD_LOAD, index, word, 16'($urandom));
      if (index < TABLE_LAST) begin
         known_symbols.push_back(index[15:0]);
      end
   endtask

   task automatic encode_symbol(logic [15:0] sym);
      send_request(CMD_ENCODE, INDEX_BITS'($urandom), {$urandom, $urandom}, sym);
   endtask

   task automatic send_run(logic [15:0] sym, int n);
      repeat (n) encode_symbol(sym);
   endtask

   task automatic flush_block();
      send_request(CMD_FLUSH, INDEX_BITS'($urandom), {$urandom, $urandom}, 16'($urandom));
   endtask

   task automatic send_noise();
      send_request(CMD_NONE, INDEX_BITS'($urandom), {$urandom, $urandom}, 16'($urandom));
   endtask

   // Waits until every predicted transfer has arrived and the block has gone quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (chunk_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_escape_index(logic [INDEX_BITS-1:0] value);
      csr_valid          <= 1'b1;
      csr_run_code_index <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      escape_index = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] make_word(logic [CODE_BITS-1:0] code,
                                             logic [LEN_BITS-1:0] len);
      return {code, len};
   endfunction

   function automatic logic [63:0] random_code_word();
      logic [63:0] w;
      int          r;
      w = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 5) begin
         w[LEN_BITS-1:0] = '0;
      end else if (r < 75) begin
         w[LEN_BITS-1:0] = LEN_BITS'($urandom_range(1, 12));
      end else if (r < 87) begin
         w[LEN_BITS-1:0] = LEN_BITS'($urandom_range(13, 40));
      end else if (r < 95) begin
         w[LEN_BITS-1:0] = LEN_BITS'($urandom_range(41, MAX_CODE_LEN));
      end else begin
         w[LEN_BITS-1:0] = LEN_BITS'($urandom_range(MAX_CODE_LEN + 1, LEN_FIELD_MAX));
      end
      return w;
   endfunction

   function automatic logic [15:0] pick_symbol();
      return known_symbols[$urandom_range(0, known_symbols.size() - 1)];
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_loads_and_empty_block();
      idle_on = 1'b0;
      write_escape_index(TABLE_LAST);
      load_entry('0, make_word(CODE_BITS'(9'h155), LEN_BITS'(9)));
      // All ones: the length field is above the maximum and gets clamped.
      load_entry(INDEX_BITS'(16'hffff), '1);
      load_entry(TABLE_LAST, make_word(CODE_BITS'(3'h5), LEN_BITS'(3)));
      load_entry(INDEX_BITS'(16'h1234), make_word(CODE_BITS'({$urandom, $urandom}), '0));
      load_entry(INDEX_BITS'(16'h00a5),
                 make_word(CODE_BITS'({$urandom, $urandom}), LEN_BITS'(MAX_CODE_LEN)));
      load_entry(INDEX_BITS'(16'h8001), make_word(CODE_BITS'(1), LEN_BITS'(1)));
      // Code bits above the length must not be sent.
      load_entry(INDEX_BITS'(16'h7ffe), make_word('1 ^ CODE_BITS'(5'h0d), LEN_BITS'(5)));
      // Loads beyond the table are dropped.
      load_entry(INDEX_ALL_ONES, {$urandom, $urandom});
      load_entry(TABLE_LAST + 1'b1, {$urandom, $urandom});
      send_noise();
      flush_block();
   endtask

   task automatic test_symbol_stream();
      idle_on = 1'b1;
      encode_symbol(16'h0000);
      encode_symbol(16'hffff);
      encode_symbol(16'hffff);
      encode_symbol(16'h1234);
      send_noise();
      encode_symbol(16'h00a5);
      encode_symbol(16'h8001);
      encode_symbol(16'h7ffe);
      encode_symbol(16'h0000);
      flush_block();
      // A block made only of empty codes still reports its zero bit total.
      encode_symbol(16'h1234);
      encode_symbol(16'h1234);
      flush_block();
      flush_block();
   endtask

   task automatic test_run_escape();
      settle_block();
      write_escape_index(TABLE_LAST);
      idle_on = 1'b1;
      // One repeat past the escape threshold: code, escape code and count.
      send_run(pick_symbol(), int'(RUN_ESCAPE_MIN) + 2);
      flush_block();
   endtask

   task automatic test_output_holdoff();
      idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < 24; k++) begin
         encode_symbol(k[0] ? 16'h8001 : 16'h0000);
      end
      flush_block();
   endtask

   task automatic test_random_traffic();
      int items;
      int r;
      int n;
      logic [INDEX_BITS-1:0] index;
      settle_block();
      write_escape_index({1'b0, pick_symbol()});
      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            idle_on = $urandom_range(0, 2) != 0;
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               n = $urandom_range(1, 3);
            end else if (r < 9) begin
               n = $urandom_range(4, 8);
            end else begin
               n = $urandom_range(int'(RUN_ESCAPE_MIN) - 2, int'(RUN_ESCAPE_MIN) + 4);
            end
            send_run(pick_symbol(), n);
            items += n;
            if ($urandom_range(0, 9) == 0) begin
               flush_block();
               items++;
            end
         end else if (r < 75) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               index = INDEX_BITS'($urandom_range(0, 16'hffff));
            end else if (r < 9) begin
               index = {1'b0, pick_symbol()};
            end else begin
               index = escape_index;
            end
            load_entry(index, random_code_word());
            items++;
         end else if (r < 85) begin
            flush_block();
            items++;
         end else if (r < 92) begin
            send_noise();
         end else begin
            load_entry(INDEX_BITS'($urandom_range(int'(TABLE_LAST) + 1, int'(INDEX_ALL_ONES))),
                       {$urandom, $urandom});
         end
      end
      flush_block();
   endtask

   initial begin : main_sequence
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_cmd            <= CMD_NONE;
      req_table_index    <= '0;
      req_table_word     <= '0;
      req_symbol         <= '0;
      rsp_stall          <= 1'b0;
      csr_valid          <= 1'b0;
      csr_run_code_index <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_loads_and_empty_block();
      test_symbol_stream();
      test_run_escape();
      test_output_holdoff();
      test_random_traffic();

      settle_block();
      if (chunk_q.size() != 0) begin
         report_mismatch("transfers never delivered", 64'(chunk_q.size()), '0);
      end
      $display("Run: %0d requests accepted, %0d output transfers checked in %0d cycles.",
               requests_sent, chunks_checked, cycle_count);
      $display("Covered table loads, empty blocks, %0d run escapes, random runs and loads,",
               escapes_predicted);
      $display("and a long output hold-off that backs up the input.");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/hrse_pkg.sv
rtl/hrse_push_unit.sv
rtl/huffman_rle_symbol_encoder_core.sv
rtl/hrse_checker.sv
tb/sv/tb_huffman_rle_symbol_encoder_core.sv
